### design/integer_to_radix_ascii_top_macros.svh
// Assertion macros for the integer to radix ASCII converter.
`ifndef INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ITRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ITRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITRA_ASSERT_IMP(label, ante, cons, msg)
`define ITRA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### design/itra_pkg.sv
// Shared types, constants and helper functions for the radix ASCII converter.
package itra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int OUT_TDATA_W     = 8;
  localparam int STEP_BITS       = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DECIMAL     = RADIX_W'(10);

  localparam logic [DIGIT_W-1:0] LARGEST_DEC_DIGIT = DIGIT_W'(9);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h7a;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIVIDE,
    PH_PREP,
    PH_SIGN,
    PH_EMIT
  } phase_t;

  typedef struct packed {
    logic load;
    logic div_en;
    logic sign_load;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic minus;
    logic last_digit;
    logic out_free;
    logic cnt_zero;
  } dp_stat_t;

  function automatic logic [RADIX_W-1:0] eff_radix(logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of_digit(logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > LARGEST_DEC_DIGIT) begin
      c = CHAR_W'(d - DIGIT_W'(DECIMAL)) + CHAR_A;
    end else begin
      c = CHAR_W'(d) + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

### design/itra_ctrl.sv
// Controller state machine sequencing divide, sign and digit output phases.
module itra_ctrl
  import itra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  phase_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      PH_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = PH_DIVIDE;
        end
      end
      PH_DIVIDE: begin
        cmd.div_en = 1'b1;
        if (stat.div_done) begin
          state_nxt = PH_PREP;
        end
      end
      PH_PREP: begin
        state_nxt = stat.minus ? PH_SIGN : PH_EMIT;
      end
      PH_SIGN: begin
        if (stat.out_free) begin
          cmd.sign_load = 1'b1;
          state_nxt     = PH_EMIT;
        end
      end
      PH_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.last_digit) begin
            state_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        state_nxt = PH_IDLE;
      end
    endcase
  end

endmodule

### design/itra_dpath.sv
// Datapath: radix register, shared divide unit, digit store and output register.
module itra_dpath
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_radix,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last
);

  localparam int CHUNKS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W   = CHUNKS * STEP_BITS;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int ADDR_W  = $clog2(VALUE_WIDTH);
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DEPTH   = 1 << ADDR_W;

  logic [RADIX_W-1:0] radix_r;
  logic [RADIX_W-1:0] base;
  logic [DIV_W-1:0]   mag_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   rd_idx;
  logic               minus_r;
  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rd_data_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic [DIV_W-1:0]   div_q;
  logic [DIGIT_W-1:0] div_rem;
  logic               last_chunk;
  logic               load_minus;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic               out_free;

  assign base       = eff_radix(radix_r);
  assign last_chunk = (chunk_r == CHUNK_W'(CHUNKS - 1));
  assign load_minus = in_value[VALUE_WIDTH-1] && (base == DECIMAL);
  assign load_mag   = load_minus ? (~in_value + VALUE_WIDTH'(1)) : in_value;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    logic [DIV_W-1:0]   q;
    logic [DIGIT_W:0]   r;
    q = mag_r;
    r = {1'b0, rem_r};
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[DIGIT_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, base}) begin
        r    = r - {1'b0, base};
        q[0] = 1'b1;
      end
    end
    div_q   = q;
    div_rem = r[DIGIT_W-1:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.div_en && last_chunk) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.emit_load) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign rd_idx = cnt_nxt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_RESET;
      cnt_r       <= '0;
      chunk_r     <= '0;
      minus_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        radix_r <= cfg_radix;
      end
      if (cmd.load) begin
        chunk_r <= '0;
        minus_r <= load_minus;
      end else if (cmd.div_en) begin
        chunk_r <= last_chunk ? '0 : chunk_r + CHUNK_W'(1);
      end
      if (cmd.sign_load || cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= DIV_W'(load_mag);
      rem_r <= '0;
    end else if (cmd.div_en) begin
      mag_r <= div_q;
      rem_r <= last_chunk ? '0 : div_rem;
    end
    if (cmd.sign_load) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_char_r <= char_of_digit(rd_data_r);
      out_last_r <= (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en && last_chunk) begin
      mem[cnt_r[ADDR_W-1:0]] <= div_rem;
    end
    rd_data_r <= mem[rd_idx[ADDR_W-1:0]];
  end

  always_comb begin
    stat            = '0;
    stat.div_done   = last_chunk && (div_q == '0);
    stat.minus      = minus_r;
    stat.last_digit = (cnt_r == CNT_W'(1));
    stat.out_free   = out_free;
    stat.cnt_zero   = (cnt_r == '0);
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

### design/integer_to_radix_ascii_top.sv
// Integer to radix ASCII converter, top level.
// Flow: accept, then each digit is divided out of the value in a pass over its 8-bit chunks
// (CHUNKS: VALUE_WIDTH/8 rounded up, 4 at 32 bits) through the shared 8-bit-per-cycle divide
// unit, then a prep state, an optional minus and one character per digit, held by output stalls.
// Throughput: one item at a time; the next is taken once the last character is loaded.
// Reset: synchronous, active low; clears control state and sets the radix to 10.
// The digit store is not cleared.
`include "integer_to_radix_ascii_top_macros.svh"
module integer_to_radix_ascii_top
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [RADIX_W-1:0]                  cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]              out_tdata,  // character, zero pad
  output logic                                out_tlast
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [CHAR_W-1:0] out_char;

  assign cfg_ready = 1'b1;

  itra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itra_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_radix (cfg_data),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'(out_char);

  `ITRA_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `ITRA_ASSERT_IMP(a_idle_store_empty, in_tready, stat.cnt_zero, "digits left when idle")
  `ITRA_ASSERT_IMP(a_char_legal, out_tvalid, (out_char == CHAR_MINUS) || ((out_char >= CHAR_ZERO) && (out_char <= CHAR_NINE)) || ((out_char >= CHAR_A) && (out_char <= CHAR_Z)), "illegal character")
  `ITRA_ASSERT_IMP(a_minus_not_last, out_tvalid && (out_char == CHAR_MINUS), !out_tlast, "minus marked last")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the integer to radix ASCII converter.
module tb_top;
  import itra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W        = VALUE_WIDTH_DEF;
  localparam int IN_TDATA_W     = ((VALUE_W + 7) / 8) * 8;
  localparam int IDLE_LIMIT     = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ITEMS_PER_PASS = 28;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [RADIX_W-1:0]     cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // value
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // character, zero pad
  logic                   out_tlast;

  char_beat_t         expected_chars[$];
  char_beat_t         head_char;
  logic [RADIX_W-1:0] radix_setting;
  int                 fail_count;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 rx_hold_left;
  logic               hold_req;
  int                 quiet_cycles;

  integer_to_radix_ascii_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void queue_digits_of(input logic [VALUE_W-1:0] v);
    logic [RADIX_W-1:0] base;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[VALUE_W];
    logic [DIGIT_W-1:0] d;
    int                 n;
    char_beat_t         beat;
    if (radix_setting < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_setting > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_setting;
    end
    neg = v[VALUE_W-1] && (base == DECIMAL);
    mag = neg ? -v : v;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0);
    if (neg) begin
      expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[i];
      if (d > LARGEST_DEC_DIGIT) begin
        beat.ch = CHAR_A + CHAR_W'(d - DIGIT_W'(DECIMAL));
      end else begin
        beat.ch = CHAR_ZERO + CHAR_W'(d);
      end
      beat.last = (i == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'(v);
    do @(posedge clk); while (!in_tready);
    queue_digits_of(v);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = r;
    do @(posedge clk); while (!cfg_ready);
    radix_setting = r;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = VALUE_W'($urandom_range(0, 40));
      1: v = -VALUE_W'($urandom_range(1, 40));
      2: v = {1'b0, {(VALUE_W-1){1'b1}}} - VALUE_W'($urandom_range(0, 20));
      3: v = {1'b1, {(VALUE_W-1){1'b0}}} + VALUE_W'($urandom_range(0, 20));
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 4) == 0) begin
      return RADIX_W'($urandom_range(0, 63));
    end
    return RADIX_W'($urandom_range(2, 36));
  endfunction

  task automatic test_decimal_default();
    send_value('0);
    send_value(VALUE_W'(1));
    send_value('1);
    send_value(VALUE_W'(9));
    send_value(VALUE_W'(10));
    send_value(-VALUE_W'(10));
    send_value({1'b0, {(VALUE_W-1){1'b1}}});
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    send_value(VALUE_W'(1234567890));
  endtask

  task automatic test_radix_edges();
    write_radix(RADIX_MIN);
    send_value('1);
    send_value('0);
    write_radix(RADIX_MAX);
    send_value(VALUE_W'(35));
    send_value('1);
    write_radix(RADIX_W'(0));
    send_value(VALUE_W'(5));
    write_radix(RADIX_W'(1));
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    write_radix(RADIX_MAX + RADIX_W'(1));
    send_value(VALUE_W'(36));
    write_radix('1);
    send_value('1);
    write_radix(RADIX_W'(16));
    send_value(VALUE_W'(32'hdeadbeef));
    send_value(VALUE_W'(10));
    write_radix(RADIX_W'(8));
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
  endtask

  task automatic test_backpressure();
    write_radix(RADIX_MIN);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    repeat (6) send_value(VALUE_W'($urandom));
    drain_results();
  endtask

  task automatic test_random();
    int tx_pct[3] = '{28, 68, 0};
    int rx_pct[3] = '{68, 28, 0};
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      for (int i = 0; i < ITEMS_PER_PASS; i++) begin
        if (i % 12 == 0) begin
          write_radix(random_radix());
        end
        send_value(random_value());
      end
    end
  endtask

  task automatic finish_run();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      out_tready = 1'b0;
      rx_hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, got %h last %b", $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        head_char = expected_chars.pop_front();
        if (out_tdata !== {1'b0, head_char.ch} || out_tlast !== head_char.last) begin
          $display("%0t: character mismatch, expected %h last %b, got %h last %b",
                   $time, {1'b0, head_char.ch}, head_char.last, out_tdata, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    hold_req      = 1'b0;
    rx_hold_left  = 0;
    quiet_cycles  = 0;
    fail_count    = 0;
    tx_idle_pct   = 28;
    rx_idle_pct   = 68;
    radix_setting = RADIX_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_decimal_default();
    test_radix_edges();
    test_backpressure();
    test_random();
    finish_run();
  end

endmodule
